// ----- design/dcrd_pkg.sv -----
// ----------------------------------------------------------------------------
// dcrd_pkg
// Shared types and constants of the decimal count run-length decoder.
// ----------------------------------------------------------------------------
package dcrd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned MAX_RUN = 64;
    localparam int unsigned WIDE_W  = COUNT_W + DIGIT_W;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] END_OF_STR = 8'h00;

    typedef enum logic {
        ALU_MAC = 1'b0,
        ALU_DEC = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [DIGIT_W-1:0]  digit;
    } t_alu_req;

    typedef struct packed {
        logic [COUNT_W-1:0]  result;
        logic                sat;
    } t_alu_rsp;

endpackage

// ----- design/dcrd_alu.sv -----
// ----------------------------------------------------------------------------
// dcrd_alu
// Shared count unit: decimal multiply-accumulate with saturation, or decrement.
// ----------------------------------------------------------------------------
module dcrd_alu (
    input  logic [dcrd_pkg::COUNT_W-1:0] i_acc,
    input  dcrd_pkg::t_alu_req           i_req,
    output dcrd_pkg::t_alu_rsp           o_rsp
);

    logic [dcrd_pkg::WIDE_W-1:0] wide;

    assign wide = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0}
                + {{(dcrd_pkg::WIDE_W-dcrd_pkg::DIGIT_W){1'b0}}, i_req.digit};

    always_comb begin
        o_rsp.sat    = 1'b0;
        o_rsp.result = i_acc;
        unique case (i_req.op)
            dcrd_pkg::ALU_MAC: begin
                if (wide > dcrd_pkg::WIDE_W'(dcrd_pkg::MAX_RUN)) begin
                    o_rsp.sat    = 1'b1;
                    o_rsp.result = dcrd_pkg::COUNT_W'(dcrd_pkg::MAX_RUN);
                end else begin
                    o_rsp.result = wide[dcrd_pkg::COUNT_W-1:0];
                end
            end
            dcrd_pkg::ALU_DEC: begin
                o_rsp.result = i_acc - dcrd_pkg::COUNT_W'(1);
            end
            default: begin
                o_rsp.result = i_acc;
            end
        endcase
    end

endmodule

// ----- design/decimal_count_rle_decoder.sv -----
// ----------------------------------------------------------------------------
// decimal_count_rle_decoder
// Decodes a byte stream in which decimal digits give the repeat count of the
// literal byte that follows them.
// ----------------------------------------------------------------------------
// A digit byte or a zero byte is taken in the idle state and produces no
// output. A literal byte moves the block to the emit state, where the input
// side is not ready until all n copies of the run (n from 1 to 64) are loaded;
// the copy count is held in a single down counter that feeds the output
// register one copy per cycle while the output side accepts. Counts above 64
// saturate and every copy of that run carries the clipped flag in tuser.
module decimal_count_rle_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] clipped
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic [dcrd_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_ovf, n_ovf;
    logic                         r_clip, n_clip;
    logic [dcrd_pkg::BYTE_W-1:0]  r_lit, n_lit;
    logic                         r_m_valid, n_m_valid;
    logic [dcrd_pkg::BYTE_W-1:0]  r_m_data, n_m_data;
    logic                         r_m_last, n_m_last;
    logic                         r_m_user, n_m_user;

    dcrd_pkg::t_alu_req alu_req;
    dcrd_pkg::t_alu_rsp alu_rsp;

    logic in_xfer;
    logic is_digit;
    logic load;
    logic [dcrd_pkg::BYTE_W-1:0] digit_off;

    assign s_tready  = (r_state == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign is_digit  = (s_tdata >= dcrd_pkg::CHAR_ZERO) && (s_tdata <= dcrd_pkg::CHAR_NINE);
    assign digit_off = s_tdata - dcrd_pkg::CHAR_ZERO;
    assign load      = (r_state == ST_EMIT) && (!r_m_valid || m_tready);

    assign alu_req.op    = (r_state == ST_EMIT) ? dcrd_pkg::ALU_DEC : dcrd_pkg::ALU_MAC;
    assign alu_req.digit = digit_off[dcrd_pkg::DIGIT_W-1:0];

    dcrd_alu u_alu (
        .i_acc (r_count),
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_clip    = r_clip;
        n_lit     = r_lit;
        n_m_valid = r_m_valid && !m_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        n_m_user  = r_m_user;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    priority if (s_tdata == dcrd_pkg::END_OF_STR) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else if (is_digit) begin
                        n_count = alu_rsp.result;
                        n_ovf   = r_ovf || alu_rsp.sat;
                    end else begin
                        n_count = (r_count == '0) ? dcrd_pkg::COUNT_W'(1) : r_count;
                        n_clip  = r_ovf;
                        n_ovf   = 1'b0;
                        n_lit   = s_tdata;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (load) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_lit;
                    n_m_last  = (r_count == dcrd_pkg::COUNT_W'(1));
                    n_m_user  = r_clip;
                    n_count   = alu_rsp.result;
                    if (r_count == dcrd_pkg::COUNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clip   <= n_clip;
        r_lit    <= n_lit;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        r_m_user <= n_m_user;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;
    assign m_tuser  = r_m_user;

endmodule

// ----- tb/sv/decimal_count_rle_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_count_rle_decoder_test
// Self-checking bench for the decimal count run-length decoder. Encoded bytes
// go in on the slave stream, and a scoreboard predicts every decoded copy
// with its last and clipped flags. Each output transfer is compared with the
// oldest predicted copy. Directed strings cover the count limits, saturation,
// zero counts and the string terminator. Random strings follow under
// changing idle patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [dcrd_pkg::BYTE_W-1:0] out_byte;
    logic                        run_last;
    logic                        clipped;
} t_decoded_copy;

class rle_scoreboard;
    t_decoded_copy                expected_copies[$];
    logic [dcrd_pkg::COUNT_W-1:0] count_acc;
    logic                         count_sat;
    int unsigned                  inputs_seen;
    int unsigned                  runs_seen;
    int unsigned                  clipped_runs;
    int unsigned                  copies_checked;

    function new();
        count_acc      = '0;
        count_sat      = 1'b0;
        inputs_seen    = 0;
        runs_seen      = 0;
        clipped_runs   = 0;
        copies_checked = 0;
    endfunction

    function int unsigned outstanding();
        return expected_copies.size();
    endfunction

    function void note_input(input logic [dcrd_pkg::BYTE_W-1:0] b);
        int unsigned next_count;
        int unsigned copies;
        t_decoded_copy one_copy;
        inputs_seen++;
        if (b == dcrd_pkg::END_OF_STR) begin
            count_acc = '0;
            count_sat = 1'b0;
        end else if (b >= dcrd_pkg::CHAR_ZERO && b <= dcrd_pkg::CHAR_NINE) begin
            next_count = int'(count_acc) * 10 + int'(b - dcrd_pkg::CHAR_ZERO);
            if (next_count > dcrd_pkg::MAX_RUN) begin
                next_count = dcrd_pkg::MAX_RUN;
                count_sat  = 1'b1;
            end
            count_acc = dcrd_pkg::COUNT_W'(next_count);
        end else begin
            copies = (count_acc == 0) ? 1 : int'(count_acc);
            if (copies > dcrd_pkg::MAX_RUN) begin
                copies = dcrd_pkg::MAX_RUN;
            end
            for (int unsigned k = 0; k < copies; k++) begin
                one_copy.out_byte = b;
                one_copy.run_last = (k + 1 == copies);
                one_copy.clipped  = count_sat;
                expected_copies.push_back(one_copy);
            end
            runs_seen++;
            if (count_sat) begin
                clipped_runs++;
            end
            count_acc = '0;
            count_sat = 1'b0;
        end
    endfunction

    function bit check_output(input logic [dcrd_pkg::BYTE_W-1:0] d, input logic l,
                              input logic u, output string why);
        t_decoded_copy want;
        if (expected_copies.size() == 0) begin
            why = $sformatf("output byte %02h last %b clipped %b with nothing pending",
                            d, l, u);
            return 1'b1;
        end
        want = expected_copies.pop_front();
        copies_checked++;
        if (d !== want.out_byte || l !== want.run_last || u !== want.clipped) begin
            why = $sformatf({"got byte %02h last %b clipped %b, ",
                             "wanted byte %02h last %b clipped %b"},
                            d, l, u, want.out_byte, want.run_last, want.clipped);
            return 1'b1;
        end
        why = "";
        return 1'b0;
    endfunction
endclass

module decimal_count_rle_decoder_test;

    localparam int unsigned TAIL_CYCLES   = 80;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned PHASE_ITEMS   = 80;

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [dcrd_pkg::BYTE_W-1:0] s_tdata  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [dcrd_pkg::BYTE_W-1:0] m_tdata;
    logic                        m_tlast;
    logic                        m_tuser;

    rle_scoreboard     board;
    int unsigned       tx_idle_pct   = 0;
    int unsigned       rx_idle_pct   = 0;
    int unsigned       items_sent    = 0;
    int unsigned       mismatches    = 0;
    logic              pressure_start = 1'b0;
    logic              rx_hold        = 1'b0;

    logic [dcrd_pkg::BYTE_W-1:0] directed_bytes [26] = '{
        "0", "a",
        "b",
        "1", 8'hFF,
        "6", "4", 8'h01,
        "6", "5", 8'h7F,
        "9", "9", "9", 8'h2F,
        "5", dcrd_pkg::END_OF_STR, 8'h3A,
        "0", "0", 8'h80,
        "3", "8", 8'h55,
        "7", dcrd_pkg::END_OF_STR
    };

    decimal_count_rle_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        string why;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                board.note_input(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (board.check_output(m_tdata, m_tlast, m_tuser, why)) begin
                    report_mismatch(why);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial begin
        wait (pressure_start);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic send_byte(input logic [dcrd_pkg::BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_decimal(input int unsigned value);
        string digits;
        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++) begin
            send_byte(digits[i]);
        end
    endtask

    function automatic logic [dcrd_pkg::BYTE_W-1:0] pick_literal();
        logic [dcrd_pkg::BYTE_W-1:0] b;
        do begin
            b = dcrd_pkg::BYTE_W'($urandom_range(1, 255));
        end while (b >= dcrd_pkg::CHAR_ZERO && b <= dcrd_pkg::CHAR_NINE);
        return b;
    endfunction

    task automatic send_random_group();
        int unsigned pick;
        int unsigned value;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            value = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0) begin
                value = $urandom_range(13, dcrd_pkg::MAX_RUN);
            end
            if ($urandom_range(0, 7) == 0) begin
                send_byte(dcrd_pkg::CHAR_ZERO);
            end
            if (value != 0 || $urandom_range(0, 1) == 1) begin
                send_decimal(value);
            end
            send_byte(pick_literal());
        end else if (pick < 75) begin
            send_decimal($urandom_range(dcrd_pkg::MAX_RUN + 1, 99999));
            send_byte(pick_literal());
        end else if (pick < 85) begin
            if ($urandom_range(0, 1) == 1) begin
                send_decimal($urandom_range(0, 200));
            end
            send_byte(dcrd_pkg::END_OF_STR);
        end else begin
            send_byte(dcrd_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_outputs();
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
        int unsigned stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) begin
            send_random_group();
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 9;
        rx_idle_pct = 64;
        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i]);
        end

        run_random_phase(9, 64);
        run_random_phase(64, 9);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pressure_start = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_decimal($urandom_range(20, 40));
            send_byte(pick_literal());
        end
        run_random_phase(0, 0);

        s_tvalid <= 1'b0;
        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.outstanding() != 0) begin
            report_mismatch($sformatf("%0d decoded copies never arrived", board.outstanding()));
        end

        $display("Covered %0d input transfers and %0d literal runs, %0d of them clipped.",
                 board.inputs_seen, board.runs_seen, board.clipped_runs);
        $display("Checked %0d output copies under three idle patterns and a long hold-off.",
                 board.copies_checked);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("timeout with %0d decoded copies pending", board.outstanding());
        $display("FAILURE");
        $finish;
    end

endmodule
